// File: hw/rtl/tkb_pkg.sv
// ----------------------------------------------------------------------------
// tkb_pkg
// Shared types and constants of the transparent-key pixel block transfer:
// register indexes, reset values, mode codes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package tkb_pkg;

  // Configuration port geometry
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegSrcOrigin  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDstOrigin  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSrcStride  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDstStride  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBlitWidth  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegBlitHeight = 3'd5;
  localparam logic [CfgIdxW-1:0] RegBlitMode   = 3'd6;

  // Field widths
  localparam int unsigned AddrW  = 32;
  localparam int unsigned DimW   = 16;
  localparam int unsigned PixelW = 8;
  localparam int unsigned ModeW  = 2;

  // Reset value of both row strides
  localparam logic [DimW-1:0] StrideReset = 16'd320;

  // Transfer modes; the remaining codes never write
  localparam logic [ModeW-1:0] ModeCopy    = 2'd0;
  localparam logic [ModeW-1:0] ModeOverlay = 2'd1;

  // Transparent color in overlay mode
  localparam logic [PixelW-1:0] KeyColor = 8'd0;

  // One result transaction
  typedef struct packed {
    logic [AddrW-1:0]  src_addr;
    logic [AddrW-1:0]  dst_addr;
    logic [PixelW-1:0] pixel;
    logic              write_enable;
    logic              last;
  } result_t;

endpackage : tkb_pkg

`default_nettype wire

// File: hw/rtl/tkb_in_if.sv
// ----------------------------------------------------------------------------
// tkb_in_if
// Source pixel channel: valid/ready handshake carrying one pixel.
// ----------------------------------------------------------------------------
`default_nettype none

interface tkb_in_if;

  logic                          valid;
  logic                          ready;
  logic [tkb_pkg::PixelW-1:0]    src_pixel;

  modport source (output valid, output src_pixel, input ready);
  modport sink   (input valid, input src_pixel, output ready);

endinterface : tkb_in_if

`default_nettype wire

// File: hw/rtl/tkb_out_if.sv
// ----------------------------------------------------------------------------
// tkb_out_if
// Result channel: valid/ready handshake carrying addresses, pixel and flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface tkb_out_if;

  logic                          valid;
  logic                          ready;
  logic [tkb_pkg::AddrW-1:0]     src_addr;
  logic [tkb_pkg::AddrW-1:0]     dst_addr;
  logic [tkb_pkg::PixelW-1:0]    pixel;
  logic                          write_enable;
  logic                          last;

  modport source (output valid, output src_addr, output dst_addr, output pixel,
                  output write_enable, output last, input ready);
  modport sink   (input valid, input src_addr, input dst_addr, input pixel,
                  input write_enable, input last, output ready);

endinterface : tkb_out_if

`default_nettype wire

// File: hw/rtl/tkb_addr.sv
// ----------------------------------------------------------------------------
// tkb_addr
// Byte address of one pixel: x + (y + row) * stride + col, modulo 2^32.
// ----------------------------------------------------------------------------
`default_nettype none

module tkb_addr (
  input  wire logic [tkb_pkg::AddrW-1:0] origin_i,
  input  wire logic [tkb_pkg::DimW-1:0]  stride_i,
  input  wire logic [tkb_pkg::DimW-1:0]  row_i,
  input  wire logic [tkb_pkg::DimW-1:0]  col_i,
  output logic      [tkb_pkg::AddrW-1:0] addr_o
);
  import tkb_pkg::*;

  logic [DimW:0]       ypos;
  logic [2*DimW:0]     row_off;

  // Absolute row, one bit wider so the carry survives
  assign ypos    = {1'b0, origin_i[AddrW-1:DimW]} + {1'b0, row_i};
  assign row_off = ypos * {1'b0, stride_i};

  // Add column origin and column, wrap at the address width
  assign addr_o = row_off[AddrW-1:0]
                + {{(AddrW-DimW){1'b0}}, origin_i[DimW-1:0]}
                + {{(AddrW-DimW){1'b0}}, col_i};

endmodule : tkb_addr

`default_nettype wire

// File: hw/rtl/transparent_key_blitter.sv
// ----------------------------------------------------------------------------
// transparent_key_blitter
// Pixel block transfer with a transparent color key: turns a stream of source
// pixels into source/destination byte addresses, pixel and write enable.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake     payload
//  pix_i     in    valid/ready   src_pixel[7:0]
//  res_o     out   valid/ready   src_addr[31:0] dst_addr[31:0] pixel[7:0]
//                                write_enable last
//  cfg       in    cfg_we_i      cfg_idx_i[2:0] cfg_wdata_i[31:0]
//
//  One pixel per cycle sustained while res_o is ready; each pixel passes the
//  position stage, then the result stage holding the multiplied addresses.
//  Reset clears the counters, the pipeline and loads the register defaults.
//  A stalled result stalls the position stage only when both stages are full.
//  With a zero width or height a pixel is taken and dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module transparent_key_blitter (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [tkb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [tkb_pkg::CfgDataW-1:0]  cfg_wdata_i,
  tkb_in_if.sink                             pix_i,
  tkb_out_if.source                          res_o
);
  import tkb_pkg::*;

  // Configuration registers
  logic [AddrW-1:0] src_origin_q, dst_origin_q;
  logic [DimW-1:0]  src_stride_q, dst_stride_q;
  logic [DimW-1:0]  blit_width_q, blit_height_q;
  logic [ModeW-1:0] blit_mode_q;

  // Position counters
  logic [DimW-1:0]  col_rem_q, col_rem_d;
  logic [DimW-1:0]  row_q, row_d;

  // Position stage
  logic             s1_valid_q;
  logic [DimW-1:0]  s1_row_q, s1_col_q;
  logic [PixelW-1:0] s1_pix_q;
  logic             s1_we_q, s1_last_q;

  // Result stage
  logic             out_valid_q;
  result_t          out_q;

  logic             in_fire, empty_blk, out_load, s1_load;
  logic [DimW-1:0]  cur_rem, cur_col, row_inc;
  logic             cur_last, cur_we;
  logic [AddrW-1:0] src_addr, dst_addr;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_origin_q  <= '0;
      dst_origin_q  <= '0;
      src_stride_q  <= StrideReset;
      dst_stride_q  <= StrideReset;
      blit_width_q  <= '0;
      blit_height_q <= '0;
      blit_mode_q   <= ModeCopy;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegSrcOrigin:  src_origin_q  <= cfg_wdata_i;
        RegDstOrigin:  dst_origin_q  <= cfg_wdata_i;
        RegSrcStride:  src_stride_q  <= cfg_wdata_i[DimW-1:0];
        RegDstStride:  dst_stride_q  <= cfg_wdata_i[DimW-1:0];
        RegBlitWidth:  blit_width_q  <= cfg_wdata_i[DimW-1:0];
        RegBlitHeight: blit_height_q <= cfg_wdata_i[DimW-1:0];
        RegBlitMode:   blit_mode_q   <= cfg_wdata_i[ModeW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow: result register frees when empty or taken
  assign out_load    = s1_valid_q && (!out_valid_q || res_o.ready);
  assign s1_load     = !s1_valid_q || out_load;
  assign pix_i.ready = s1_load;
  assign in_fire     = pix_i.valid && pix_i.ready;
  assign empty_blk   = (blit_width_q == '0) || (blit_height_q == '0);

  // Current column, next counters and end-of-block detection
  always_comb begin
    cur_rem   = (col_rem_q == '0) ? blit_width_q : col_rem_q;
    cur_col   = cur_rem - 1'b1;
    row_inc   = row_q + 1'b1;
    cur_last  = 1'b0;
    col_rem_d = col_rem_q;
    row_d     = row_q;
    if (in_fire) begin
      if (empty_blk) begin
        col_rem_d = '0;
        row_d     = '0;
      end else begin
        col_rem_d = cur_col;
        if (cur_col == '0) begin
          if ((row_inc == '0) || (row_inc >= blit_height_q)) begin
            cur_last = 1'b1;
            row_d    = '0;
          end else begin
            row_d = row_inc;
          end
        end
      end
    end
  end

  // Write enable per mode
  always_comb begin
    case (blit_mode_q)
      ModeCopy:    cur_we = 1'b1;
      ModeOverlay: cur_we = (pix_i.src_pixel != KeyColor);
      default:     cur_we = 1'b0;
    endcase
  end

  // Advance position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_rem_q <= '0;
      row_q     <= '0;
    end else begin
      col_rem_q <= col_rem_d;
      row_q     <= row_d;
    end
  end

  // Position stage: hold on stall, drop pixels of an empty block
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= in_fire && !empty_blk;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_row_q  <= row_q;
      s1_col_q  <= cur_col;
      s1_pix_q  <= pix_i.src_pixel;
      s1_we_q   <= cur_we;
      s1_last_q <= cur_last;
    end
  end

  // Address units for both bitmaps
  tkb_addr u_src_addr (
    .origin_i (src_origin_q),
    .stride_i (src_stride_q),
    .row_i    (s1_row_q),
    .col_i    (s1_col_q),
    .addr_o   (src_addr)
  );

  tkb_addr u_dst_addr (
    .origin_i (dst_origin_q),
    .stride_i (dst_stride_q),
    .row_i    (s1_row_q),
    .col_i    (s1_col_q),
    .addr_o   (dst_addr)
  );

  // Result register: load on advance, clear once the transaction is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.src_addr     <= src_addr;
      out_q.dst_addr     <= dst_addr;
      out_q.pixel        <= s1_pix_q;
      out_q.write_enable <= s1_we_q;
      out_q.last         <= s1_last_q;
    end
  end

  // Drive result channel
  assign res_o.valid        = out_valid_q;
  assign res_o.src_addr     = out_q.src_addr;
  assign res_o.dst_addr     = out_q.dst_addr;
  assign res_o.pixel        = out_q.pixel;
  assign res_o.write_enable = out_q.write_enable;
  assign res_o.last         = out_q.last;

endmodule : transparent_key_blitter

`default_nettype wire
